FILE: hdl/aes_kx_pkg.sv
// ----------------------------------------------------------------------------
// AES key expansion package
// Shared widths, key size codes, queue command type and the byte-level
// functions of the key schedule (S-box, Rcon, InvMixColumns).
// ----------------------------------------------------------------------------
package aes_kx_pkg;

    localparam int MAX_ROUND_KEYS_DEF = 15;
    localparam int WORD_W             = 32;
    localparam int PAIR_W             = 64;
    localparam int ROUND_W            = 4;
    localparam int CNT_W              = 4;
    localparam int KIDX_W             = 3;
    localparam int KS_W               = 2;
    localparam int S_DATA_W           = 32;
    localparam int M_DATA_W           = 72;
    localparam int M_PAD_W            = M_DATA_W - PAIR_W - ROUND_W - 1;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [KS_W-1:0]    KS_128   = 2'd0;
    localparam logic [KS_W-1:0]    KS_192   = 2'd1;
    localparam logic [KS_W-1:0]    KS_256   = 2'd2;
    localparam logic [CNT_W-1:0]   NK_128   = 4'd4;
    localparam logic [CNT_W-1:0]   NK_192   = 4'd6;
    localparam logic [CNT_W-1:0]   NK_256   = 4'd8;
    localparam logic [KIDX_W-1:0]  SUB_POS  = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [KIDX_W-1:0] idx;
        logic              store;
        logic              go;
        logic [KS_W-1:0]   sz;
    } kx_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // words per key; the unused code behaves as 256 bits
    function automatic logic [CNT_W-1:0] key_nk(input logic [KS_W-1:0] ks);
        logic [CNT_W-1:0] nk;
        unique case (ks)
            KS_128:  nk = NK_128;
            KS_192:  nk = NK_192;
            default: nk = NK_256;
        endcase
        return nk;
    endfunction

    function automatic logic [7:0] rcon_byte(input logic [ROUND_W-1:0] ri);
        logic [7:0] rc;
        unique case (ri)
            4'd0:    rc = 8'h01;
            4'd1:    rc = 8'h02;
            4'd2:    rc = 8'h04;
            4'd3:    rc = 8'h08;
            4'd4:    rc = 8'h10;
            4'd5:    rc = 8'h20;
            4'd6:    rc = 8'h40;
            4'd7:    rc = 8'h80;
            4'd8:    rc = 8'h1b;
            default: rc = 8'h36;
        endcase
        return rc;
    endfunction

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // {x*14, x*13, x*11, x*9}
    function automatic logic [31:0] inv_mul(input logic [7:0] a);
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        return {x8 ^ x4 ^ x2, x8 ^ x4 ^ a, x8 ^ x2 ^ a, x8 ^ a};
    endfunction

    function automatic logic [WORD_W-1:0] inv_mix_word(input logic [WORD_W-1:0] w);
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        p0 = inv_mul(w[31:24]);
        p1 = inv_mul(w[23:16]);
        p2 = inv_mul(w[15:8]);
        p3 = inv_mul(w[7:0]);
        return {p0[31:24] ^ p1[15:8]  ^ p2[23:16] ^ p3[7:0],
                p0[7:0]   ^ p1[31:24] ^ p2[15:8]  ^ p3[23:16],
                p0[23:16] ^ p1[7:0]   ^ p2[31:24] ^ p3[15:8],
                p0[15:8]  ^ p1[23:16] ^ p2[7:0]   ^ p3[31:24]};
    endfunction

endpackage

FILE: hdl/aes_kx_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aes_kx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/aes_kx_front.sv
// ----------------------------------------------------------------------------
// AES key expansion front end
// Accepts key words, tracks the load count and the key size register, and
// queues one command per word, marking the word that completes the key.
// ----------------------------------------------------------------------------
module aes_kx_front
    import aes_kx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key_word
    input  logic                s_tuser,   // first_word
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [KS_W-1:0]     cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output kx_cmd_t             q_push_data
);

    logic [KS_W-1:0]  key_size_reg;
    logic [CNT_W-1:0] loaded_count_reg;
    logic [CNT_W-1:0] loaded_count_next;
    logic [CNT_W-1:0] lc;
    logic [CNT_W-1:0] lc_inc;
    logic             go;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    assign lc     = s_tuser ? '0 : loaded_count_reg;
    assign lc_inc = lc + 4'd1;
    assign go     = (lc_inc >= key_nk(key_size_reg));

    always_comb
    begin
        q_push_data.word  = s_tdata[WORD_W-1:0];
        q_push_data.idx   = lc[KIDX_W-1:0];
        q_push_data.store = !lc[CNT_W-1];
        q_push_data.go    = go;
        q_push_data.sz    = key_size_reg;
    end

    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        if (q_push)
        begin
            loaded_count_next = go ? '0 : lc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg     <= KS_128;
            loaded_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                key_size_reg <= cfg_data;
            end
            loaded_count_reg <= loaded_count_next;
        end
    end

endmodule

FILE: hdl/aes_kx_fifo.sv
// ----------------------------------------------------------------------------
// AES key expansion command queue
// Short queue between the front end and the expansion engine.
// ----------------------------------------------------------------------------
module aes_kx_fifo
    import aes_kx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  kx_cmd_t push_data,
    output logic    full,
    input  logic    pop,
    output kx_cmd_t pop_data,
    output logic    pop_valid
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    kx_cmd_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic [PW:0]    count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && pop_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && pop_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/aes_kx_back.sv
// ----------------------------------------------------------------------------
// AES key expansion engine
// Stores key words, expands the schedule one word at a time in the
// word RAM, then emits encryption and decryption round keys in halves.
// ----------------------------------------------------------------------------
module aes_kx_back
    import aes_kx_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = MAX_ROUND_KEYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  kx_cmd_t             cmd,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int DEPTH = 4 * MAX_ROUND_KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = AW + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EXP_INIT = 4'd1;
    localparam logic [3:0] ST_EXP_PREV = 4'd2;
    localparam logic [3:0] ST_EXP_RD   = 4'd3;
    localparam logic [3:0] ST_EXP_WR   = 4'd4;
    localparam logic [3:0] ST_EM_RA    = 4'd5;
    localparam logic [3:0] ST_EM_RB    = 4'd6;
    localparam logic [3:0] ST_EM_MIX   = 4'd7;
    localparam logic [3:0] ST_EM_OUT   = 4'd8;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [CNT_W-1:0]    nk_reg;
    logic [ROUND_W-1:0]  nrk_reg;
    logic [AW-1:0]       idx_reg;
    logic [KIDX_W-1:0]   pos_reg;
    logic [ROUND_W-1:0]  ri_reg;
    logic                sched_reg;
    logic [ROUND_W-1:0]  rnd_reg;
    logic                half_reg;
    logic [WORD_W-1:0]   prev_reg;
    logic [WORD_W-1:0]   temp_reg;
    logic [WORD_W-1:0]   hold_reg;
    logic [PAIR_W-1:0]   pair_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic                m_tlast_reg;

    logic [CNT_W-1:0]    cmd_nk;
    logic [ROUND_W-1:0]  cmd_nk7;
    logic [ROUND_W-1:0]  max_rk;
    logic [ROUND_W-1:0]  rnd_last;
    logic [ROUND_W-1:0]  em_src;
    logic [AW-1:0]       em_addr;
    logic                exp_done;
    logic                pos_wrap;
    logic                em_final;
    logic                em_mix;
    logic                out_load;
    logic [WORD_W-1:0]   rot;
    logic [WORD_W-1:0]   temp_calc;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    aes_kx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd_nk   = key_nk(cmd.sz);
    assign cmd_nk7  = cmd_nk + 4'd7;
    assign max_rk   = ROUND_W'(MAX_ROUND_KEYS);
    assign rnd_last = nrk_reg - 4'd1;

    assign exp_done = (({1'b0, idx_reg} + 1'b1) == NW'({nrk_reg, 2'b00}));
    assign pos_wrap = ({1'b0, pos_reg} == (nk_reg - 4'd1));

    // decryption keys walk the schedule backwards
    assign em_src   = sched_reg ? (rnd_last - rnd_reg) : rnd_reg;
    assign em_addr  = AW'({em_src, half_reg, 1'b0});
    assign em_mix   = sched_reg && (rnd_reg != '0) && (rnd_reg != rnd_last);
    assign em_final = sched_reg && (rnd_reg == rnd_last) && half_reg;
    assign out_load = (state_reg == ST_EM_OUT) && (!m_tvalid_reg || m_tready);

    assign rot = {prev_reg[23:0], prev_reg[31:24]};

    always_comb
    begin
        if (pos_reg == '0)
        begin
            temp_calc = sub_word(rot) ^ {rcon_byte(ri_reg), 24'h000000};
        end
        else if ((nk_reg == NK_256) && (pos_reg == SUB_POS))
        begin
            temp_calc = sub_word(prev_reg);
        end
        else
        begin
            temp_calc = prev_reg;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(cmd.idx);
        ram_wdata = cmd.word;
        ram_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_we = cmd_pop && cmd.store;
            end
            ST_EXP_INIT:
            begin
                ram_raddr = AW'(nk_reg - 4'd1);
            end
            ST_EXP_RD:
            begin
                ram_raddr = idx_reg - AW'(nk_reg);
            end
            ST_EXP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata ^ temp_reg;
            end
            ST_EM_RA:
            begin
                ram_raddr = em_addr;
            end
            ST_EM_RB:
            begin
                ram_raddr = em_addr + 1'b1;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     state_next = (cmd_pop && cmd.go) ? ST_EXP_INIT : ST_IDLE;
            ST_EXP_INIT: state_next = ST_EXP_PREV;
            ST_EXP_PREV: state_next = ST_EXP_RD;
            ST_EXP_RD:   state_next = ST_EXP_WR;
            ST_EXP_WR:   state_next = exp_done ? ST_EM_RA : ST_EXP_RD;
            ST_EM_RA:    state_next = ST_EM_RB;
            ST_EM_RB:    state_next = ST_EM_MIX;
            ST_EM_MIX:   state_next = ST_EM_OUT;
            ST_EM_OUT:
            begin
                if (out_load)
                begin
                    state_next = em_final ? ST_IDLE : ST_EM_RA;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            nk_reg       <= NK_128;
            nrk_reg      <= max_rk;
            idx_reg      <= '0;
            pos_reg      <= '0;
            ri_reg       <= '0;
            sched_reg    <= 1'b0;
            rnd_reg      <= '0;
            half_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop && cmd.go)
            begin
                nk_reg  <= cmd_nk;
                nrk_reg <= (cmd_nk7 > max_rk) ? max_rk : cmd_nk7;
            end
            if (state_reg == ST_EXP_PREV)
            begin
                idx_reg <= AW'(nk_reg);
                pos_reg <= '0;
                ri_reg  <= '0;
            end
            if (state_reg == ST_EXP_WR)
            begin
                idx_reg <= idx_reg + 1'b1;
                pos_reg <= pos_wrap ? '0 : pos_reg + 1'b1;
                if (pos_wrap)
                begin
                    ri_reg <= ri_reg + 4'd1;
                end
                if (exp_done)
                begin
                    sched_reg <= 1'b0;
                    rnd_reg   <= '0;
                    half_reg  <= 1'b0;
                end
            end
            if (out_load)
            begin
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    if (rnd_reg == rnd_last)
                    begin
                        rnd_reg   <= '0;
                        sched_reg <= 1'b1;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                end
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXP_PREV)
        begin
            prev_reg <= ram_rdata;
        end
        else if (state_reg == ST_EXP_WR)
        begin
            prev_reg <= ram_wdata;
        end
        if (state_reg == ST_EXP_RD)
        begin
            temp_reg <= temp_calc;
        end
        if (state_reg == ST_EM_RB)
        begin
            hold_reg <= ram_rdata;
        end
        if (state_reg == ST_EM_MIX)
        begin
            pair_reg <= em_mix ? {inv_mix_word(hold_reg), inv_mix_word(ram_rdata)}
                               : {hold_reg, ram_rdata};
        end
        if (out_load)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, pair_reg, half_reg, rnd_reg};
            m_tuser_reg <= sched_reg;
            m_tlast_reg <= em_final;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/aes_key_expansion_core.sv
// ----------------------------------------------------------------------------
// AES key expansion core
// steps: a key word that does not complete the key is written to the word RAM as it is popped;
//   the completing word starts the expansion in EXP_INIT and EXP_PREV, then EXP_RD and
//   EXP_WR for each new word; each result then passes EM_RA, EM_RB, EM_MIX and EM_OUT,
//   where it waits while the previous result is still untaken (4*Nr_keys results)
// throughput: one key at a time in the engine; up to two key words queue meanwhile
// reset: rst_n clears control state and key_size to 128 bits; the word RAM
//   holds no reset value and needs no clearing pass
// ----------------------------------------------------------------------------
module aes_key_expansion_core
    import aes_kx_pkg::*;
#(
    parameter int MAX_ROUND_KEYS = MAX_ROUND_KEYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key_word[31:0]
    input  logic                s_tuser,   // first_word
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // round_index[3:0], half_index[4], pair_data[68:5]
    output logic                m_tuser,   // schedule
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [KS_W-1:0]     cfg_data   // key_size
);

    kx_cmd_t q_push_data;
    kx_cmd_t q_pop_data;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;

    aes_kx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    aes_kx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .pop_valid (q_valid)
    );

    aes_kx_back #(
        .MAX_ROUND_KEYS (MAX_ROUND_KEYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_pop_data),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hdl/aes_kx_checker.sv
// ----------------------------------------------------------------------------
// AES key expansion port checker
// Checks the result stream seen on the top level ports.
// ----------------------------------------------------------------------------
module aes_kx_checker
    import aes_kx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser,
    input  logic                m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // run ends on second half of a decryption key
    a_last_dec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser && m_tdata[4])
        else $error("last word is not a decryption second half");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] != 4'd15)
        else $error("round index out of range");

    // nothing follows the last word without a new key
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("word right after end of run");

endmodule

bind aes_key_expansion_core aes_kx_checker u_chk (.*);

FILE: dv/aes_key_expansion_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES key expansion core testbench
// Loads cipher keys of all sizes one word at a time, predicts every
// encryption and decryption round key in the bench and checks each output
// word in order. A directed table covers known keys, extreme words, restarts
// and size changes in mid-load; random keys, noise and config changes follow,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module aes_key_expansion_core_tb
    import aes_kx_pkg::*;
();

    localparam int              ROUND_KEYS_MAX = MAX_ROUND_KEYS_DEF;
    localparam int              SCHED_DEPTH    = 4 * ROUND_KEYS_MAX;
    localparam int              NO_CFG         = -1;
    localparam int              RANDOM_WORDS   = 270;
    localparam int              CYCLE_LIMIT    = 600000;
    localparam logic [KS_W-1:0] KS_UNUSED      = 2'd3;
    localparam logic [7:0]      RCON_BYTES [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    typedef struct packed {
        logic              sched;
        logic [ROUND_W-1:0] rnd;
        logic              half;
        logic [PAIR_W-1:0] pair;
        logic              last;
    } round_key_half_t;

    typedef struct {
        int          cfg_val;
        logic [31:0] word;
        logic        first;
        int          n_due;
    } key_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [KS_W-1:0]     cfg_data;

    // bench copy of the key schedule state
    logic [31:0]         key_sched [SCHED_DEPTH];
    logic [CNT_W-1:0]    words_loaded;
    logic [KS_W-1:0]     size_reg;
    logic [7:0]          sbox_lut [256];
    round_key_half_t     round_keys_due [$];

    bit                  full_rate = 1'b0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    aes_key_expansion_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[aes_key_expansion_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= full_rate || ($urandom_range(99) >= 16);
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[0])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return acc;
    endfunction

    // inverse as x^254, then the affine map
    function automatic logic [7:0] sbox_entry(input logic [7:0] x);
        logic [7:0] inv;
        inv = 8'h01;
        for (int k = 0; k < 254; k++)
            inv = gf_mul(inv, x);
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    function automatic logic [31:0] inv_mix_column(input logic [31:0] w);
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
                gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
                gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
                gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14)};
    endfunction

    function automatic int key_words_for(input logic [KS_W-1:0] ks);
        int nk;
        case (ks)
            KS_128:  nk = int'(NK_128);
            KS_192:  nk = int'(NK_192);
            default: nk = int'(NK_256);
        endcase
        return nk;
    endfunction

    function automatic logic [31:0] pick_key_word();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 32'h0000_0000;
        else if (sel == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // store one key word; on the completing word expand and queue all round keys
    task automatic predict_key_word(input logic [31:0] word, input logic first,
                                    output int n_new);
        int              nk;
        int              nrk;
        int              nwords;
        int              ri;
        int              src;
        logic [31:0]     t;
        logic [31:0]     wa;
        logic [31:0]     wb;
        round_key_half_t item;
        n_new = 0;
        nk = key_words_for(size_reg);
        nrk = (nk + 7 > ROUND_KEYS_MAX) ? ROUND_KEYS_MAX : nk + 7;
        nwords = 4 * nrk;
        if (first)
            words_loaded = '0;
        if (words_loaded < 8)
            key_sched[words_loaded] = word;
        words_loaded = words_loaded + 1'b1;
        if (words_loaded < nk)
            return;
        words_loaded = '0;

        for (int i = nk; i < nwords && i < SCHED_DEPTH; i++)
        begin
            t = key_sched[i-1];
            if (i % nk == 0)
            begin
                ri = i / nk - 1;
                t = {t[23:0], t[31:24]};
                t = sub_bytes_word(t) ^ {RCON_BYTES[ri < 10 ? ri : 9], 24'h0};
            end
            else if (nk > 6 && i % nk == 4)
            begin
                t = sub_bytes_word(t);
            end
            key_sched[i] = key_sched[i-nk] ^ t;
        end

        for (int r = 0; r < nrk; r++)
            for (int h = 0; h < 2; h++)
            begin
                item = '{1'b0, ROUND_W'(r), h[0], {key_sched[4*r+2*h], key_sched[4*r+2*h+1]},
                         1'b0};
                round_keys_due.push_back(item);
                n_new++;
            end
        for (int r = 0; r < nrk; r++)
        begin
            src = nrk - 1 - r;
            for (int h = 0; h < 2; h++)
            begin
                wa = key_sched[4*src+2*h];
                wb = key_sched[4*src+2*h+1];
                if (r != 0 && r != nrk - 1)
                begin
                    wa = inv_mix_column(wa);
                    wb = inv_mix_column(wb);
                end
                item = '{1'b1, ROUND_W'(r), h[0], {wa, wb}, 1'b0};
                round_keys_due.push_back(item);
                n_new++;
            end
        end
        round_keys_due[round_keys_due.size()-1].last = 1'b1;
    endtask

    task automatic send_key_word(input logic [31:0] word, input logic first,
                                 output int n_new);
        bit taken;
        while (!full_rate && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= first;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        predict_key_word(word, first, n_new);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (round_keys_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_key_size(input logic [KS_W-1:0] ks);
        bit taken;
        hold_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= ks;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid <= 1'b0;
        size_reg = ks;
    endtask

    // output word is taken at the next rising edge
    always @(negedge clk)
    begin
        round_key_half_t got;
        round_key_half_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[68:5], m_tlast};
            if (round_keys_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word: sched %0d round %0d half %0d %h last %0d",
                                        got.sched, got.rnd, got.half, got.pair, got.last));
            end
            else
            begin
                want = round_keys_due.pop_front();
                if (got.sched !== want.sched || got.rnd !== want.rnd || got.half !== want.half
                    || got.pair !== want.pair || got.last !== want.last)
                    flag_mismatch($sformatf({"mismatch: exp sched %0d round %0d half %0d %h last %0d,",
                                             " got sched %0d round %0d half %0d %h last %0d"},
                                            want.sched, want.rnd, want.half, want.pair, want.last,
                                            got.sched, got.rnd, got.half, got.pair, got.last));
            end
        end
    end

    initial
    begin
        key_row_t    key_rows [] = '{
            // fips-197 128-bit key right after reset
            '{NO_CFG, 32'h2b7e1516, 1'b1, 0},
            '{NO_CFG, 32'h28aed2a6, 1'b0, 0},
            '{NO_CFG, 32'habf71588, 1'b0, 0},
            '{NO_CFG, 32'h09cf4f3c, 1'b0, 44},
            // 192 bits, no restart flag after a completed key
            '{int'(KS_192), 32'hffffffff, 1'b0, 0},
            '{NO_CFG, 32'hffffffff, 1'b0, 0},
            '{NO_CFG, 32'hffffffff, 1'b0, 0},
            '{NO_CFG, 32'h00000000, 1'b0, 0},
            '{NO_CFG, 32'h00000000, 1'b0, 0},
            '{NO_CFG, 32'h00000000, 1'b0, 52},
            // unused size code, restart after one word
            '{int'(KS_UNUSED), 32'h8e73b0f7, 1'b1, 0},
            '{NO_CFG, 32'h603deb10, 1'b1, 0},
            '{NO_CFG, 32'h15ca71be, 1'b0, 0},
            '{NO_CFG, 32'h2b73aef0, 1'b0, 0},
            '{NO_CFG, 32'h857d7781, 1'b0, 0},
            '{NO_CFG, 32'h1f352c07, 1'b0, 0},
            '{NO_CFG, 32'h3b6108d7, 1'b0, 0},
            '{NO_CFG, 32'h2d9810a3, 1'b0, 0},
            '{NO_CFG, 32'h0914dff4, 1'b0, 60},
            // key shrinks to 128 bits after five words
            '{int'(KS_256), 32'h00010203, 1'b1, 0},
            '{NO_CFG, 32'h04050607, 1'b0, 0},
            '{NO_CFG, 32'h08090a0b, 1'b0, 0},
            '{NO_CFG, 32'h0c0d0e0f, 1'b0, 0},
            '{NO_CFG, 32'h10111213, 1'b0, 0},
            '{int'(KS_128), 32'ha5a5a5a5, 1'b0, 44}
        };
        int          n_new;
        int          words_sent;
        int          sel;
        int          nk;
        int          n_noise;

        rst_n     = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        for (int x = 0; x < 256; x++)
            sbox_lut[x] = sbox_entry(x[7:0]);
        for (int i = 0; i < SCHED_DEPTH; i++)
            key_sched[i] = '0;
        words_loaded = '0;
        size_reg = KS_128;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (key_rows[n])
        begin
            if (key_rows[n].cfg_val != NO_CFG)
                write_key_size(key_rows[n].cfg_val[KS_W-1:0]);
            send_key_word(key_rows[n].word, key_rows[n].first, n_new);
            if (n_new != key_rows[n].n_due)
                flag_mismatch($sformatf("row %0d: %0d round key words predicted, %0d typed",
                                        n, n_new, key_rows[n].n_due));
        end

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            full_rate = (words_sent >= 100 && words_sent < 160);
            sel = $urandom_range(99);
            if (sel < 8)
            begin
                write_key_size(KS_W'($urandom_range(3)));
            end
            else if (sel < 13)
            begin
                hold_until_drained();
            end
            else if (sel < 23)
            begin
                // broken or partial keys
                n_noise = $urandom_range(1, 5);
                repeat (n_noise)
                begin
                    send_key_word(pick_key_word(), 1'($urandom_range(1)), n_new);
                    words_sent++;
                end
            end
            else
            begin
                nk = key_words_for(size_reg);
                send_key_word(pick_key_word(), $urandom_range(9) != 0, n_new);
                words_sent++;
                for (int k = 1; k < nk; k++)
                begin
                    send_key_word(pick_key_word(), 1'b0, n_new);
                    words_sent++;
                end
            end
        end
        full_rate = 1'b0;

        s_tvalid <= 1'b0;
        while (round_keys_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (round_keys_due.size() != 0)
            flag_mismatch($sformatf("%0d round key words never arrived", round_keys_due.size()));
        if (mismatches == 0)
            $display("[aes_key_expansion_core] OK");
        else
            $display("[aes_key_expansion_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/aes_kx_pkg.sv
hdl/aes_kx_ram.sv
hdl/aes_kx_front.sv
hdl/aes_kx_fifo.sv
hdl/aes_kx_back.sv
hdl/aes_key_expansion_core.sv
hdl/aes_kx_checker.sv
dv/aes_key_expansion_core_tb.sv
